// ----- hdl/interval_maximum_search_unit_assert.svh -----
// Assertion macros shared by the interval maximum search RTL.
// Each macro expects signals named clock and reset in the using scope.
`ifndef INTERVAL_MAXIMUM_SEARCH_UNIT_ASSERT_SVH
`define INTERVAL_MAXIMUM_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IMS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define IMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/ims_pkg.sv -----
// Shared types and constants for the interval maximum search unit.
// No dependencies.
package ims_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int ITER_BITS = 6;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ACC_BITS  = 2 * WORD_BITS + 2;

   localparam logic [WORD_BITS-1:0] TEN_FIX = WORD_BITS'(10) << FRAC_BITS;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TOLERANCE = 2'd0;
   localparam logic [1:0] CSR_MAX_ITER  = 2'd1;
   localparam logic [1:0] CSR_OBJ_SEL   = 2'd2;

   typedef struct packed {
      logic done;
      logic greater;
   } ims_cmp_stat_type;

endpackage

// ----- hdl/ims_compare.sv -----
// Exact objective comparison f(u) > f(v) using one shared multiplier over several cycles.
// Depends on ims_pkg.
module ims_compare
   import ims_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 obj_sel,
   input  logic [WORD_BITS-1:0] u,
   input  logic [WORD_BITS-1:0] v,
   output ims_cmp_stat_type     stat
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN} state_type;

   state_type              state_ff;
   logic [2:0]             step_ff;
   logic [WORD_BITS-1:0]   u_ff, v_ff;
   logic                   sel_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic                   done_ff, greater_ff;

   logic [WORD_BITS-1:0]   mul_a, mul_b;
   logic [PROD_BITS-1:0]   prod_in;
   logic [WORD_BITS:0]     sum_uv;
   logic [WORD_BITS+4:0]   ten_sum;
   logic [ACC_BITS-1:0]    lhs;
   logic [WORD_BITS+7:0]   q_dist;
   logic [WORD_BITS+7:0]   k_dist;
   logic                   root_gt, dist_gt, greater_in;

   always_comb begin
      case (step_ff)
         3'd1:    begin mul_a = u_ff; mul_b = v_ff; end
         3'd2:    begin mul_a = v_ff; mul_b = v_ff; end
         default: begin mul_a = u_ff; mul_b = u_ff; end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // Sign of g(u)-g(v) follows sign(u-v) * sign(10(u+v) - (u^2+uv+v^2)).
   always_comb begin
      sum_uv  = {1'b0, u_ff} + {1'b0, v_ff};
      ten_sum = (WORD_BITS+5)'(sum_uv) * (WORD_BITS+5)'(10);
      lhs     = ACC_BITS'(ten_sum) << FRAC_BITS;
      q_dist  = (WORD_BITS+8)'(sum_uv) * (WORD_BITS+8)'(89);
      k_dist  = (WORD_BITS+8)'(16) << FRAC_BITS;
      if (u_ff > TEN_FIX)
         root_gt = 1'b0;
      else if (v_ff > TEN_FIX)
         root_gt = (u_ff != '0) && (u_ff < TEN_FIX);
      else if (u_ff == v_ff)
         root_gt = 1'b0;
      else if (u_ff > v_ff)
         root_gt = lhs > acc_ff;
      else
         root_gt = lhs < acc_ff;
      if (u_ff == v_ff)
         dist_gt = 1'b0;
      else if (u_ff > v_ff)
         dist_gt = q_dist < k_dist;
      else
         dist_gt = q_dist > k_dist;
      greater_in = sel_ff ? dist_gt : root_gt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         done_ff    <= 1'b0;
         greater_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  u_ff     <= u;
                  v_ff     <= v;
                  sel_ff   <= obj_sel;
                  prod_ff  <= '0;
                  acc_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (step_ff == 3'd4) begin
                  greater_ff <= greater_in;
                  done_ff    <= 1'b1;
                  state_ff   <= ST_IDLE;
               end else begin
                  prod_ff <= prod_in;
                  acc_ff  <= acc_ff + ACC_BITS'(prod_ff);
                  step_ff <= step_ff + 3'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign stat.done    = done_ff;
   assign stat.greater = greater_ff;

endmodule

// ----- hdl/interval_maximum_search_unit.sv -----
// Each narrowing pass runs three compares in turn on the one shared multiplier in ims_compare.
// Requests are taken only in the idle state, so a new search waits until the previous one is finished.
// A new request is taken while a finished response still waits in the output register.
// Reset is synchronous, active high; registers return to tolerance 16777, limit 40, objective 0.
module interval_maximum_search_unit
   import ims_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_interval_low,
   input  logic [WORD_BITS-1:0] req_interval_high,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_best_point,
   output logic [ITER_BITS-1:0] rsp_iterations_used,
   output logic                 rsp_limit_reached,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_LAUNCH, S_WAIT, S_UPDATE, S_FINISH}
      state_type;

   state_type              state_ff;
   logic [WORD_BITS-1:0]   tol_ff;
   logic [ITER_BITS-1:0]   max_iter_ff;
   logic                   obj_sel_ff;
   logic [WORD_BITS-1:0]   a_ff, b_ff, c_ff, l_ff, r_ff;
   logic [ITER_BITS-1:0]   iter_ff;
   logic [1:0]             idx_ff;
   logic [2:0]             gt_ff;
   logic                   rsp_valid_ff;
   logic [WORD_BITS-1:0]   rsp_best_ff;
   logic [ITER_BITS-1:0]   rsp_iter_ff;
   logic                   rsp_limit_ff;

   logic [WORD_BITS-1:0]   c_in, l_in, r_in, cmp_u, cmp_v;
   logic                   stop_in, cmp_start;
   ims_cmp_stat_type       cmp_stat;

   always_comb begin
      c_in = WORD_BITS'(({1'b0, a_ff} + {1'b0, b_ff}) >> 1);
      l_in = WORD_BITS'(({1'b0, a_ff} + {1'b0, c_in}) >> 1);
      r_in = WORD_BITS'(({1'b0, c_in} + {1'b0, b_ff}) >> 1);
      // A reversed interval counts as narrower than any tolerance.
      stop_in = (b_ff < a_ff) || ((b_ff - a_ff) < tol_ff) || (iter_ff >= max_iter_ff);
      case (idx_ff)
         2'd0:    begin cmp_u = c_ff; cmp_v = l_ff; end
         2'd1:    begin cmp_u = c_ff; cmp_v = r_ff; end
         default: begin cmp_u = l_ff; cmp_v = r_ff; end
      endcase
      cmp_start = (state_ff == S_LAUNCH);
   end

   ims_compare u_compare (
      .clock   (clock),
      .reset   (reset),
      .start   (cmp_start),
      .obj_sel (obj_sel_ff),
      .u       (cmp_u),
      .v       (cmp_v),
      .stat    (cmp_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= WORD_BITS'(16777);
         max_iter_ff  <= ITER_BITS'(40);
         obj_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TOLERANCE: tol_ff      <= csr_data;
               CSR_MAX_ITER:  max_iter_ff <= csr_data[ITER_BITS-1:0];
               CSR_OBJ_SEL:   obj_sel_ff  <= csr_data[0];
               default: ;
            endcase
         end
         // The finish state refills the output register itself.
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  a_ff     <= req_interval_low;
                  b_ff     <= req_interval_high;
                  iter_ff  <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               c_ff <= c_in;
               if (stop_in) begin
                  state_ff <= S_FINISH;
               end else begin
                  l_ff     <= l_in;
                  r_ff     <= r_in;
                  iter_ff  <= iter_ff + ITER_BITS'(1);
                  idx_ff   <= '0;
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: state_ff <= S_WAIT;
            S_WAIT: begin
               if (cmp_stat.done) begin
                  gt_ff[idx_ff] <= cmp_stat.greater;
                  if (idx_ff == 2'd2) begin
                     state_ff <= S_UPDATE;
                  end else begin
                     idx_ff   <= idx_ff + 2'd1;
                     state_ff <= S_LAUNCH;
                  end
               end
            end
            S_UPDATE: begin
               if (gt_ff[0] && gt_ff[1]) begin
                  a_ff <= l_ff;
                  b_ff <= r_ff;
               end else if (gt_ff[2]) begin
                  b_ff <= c_ff;
               end else begin
                  a_ff <= c_ff;
               end
               state_ff <= S_CHECK;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_best_ff  <= c_ff;
                  rsp_iter_ff  <= iter_ff;
                  rsp_limit_ff <= iter_ff >= max_iter_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_point      = rsp_best_ff;
   assign rsp_iterations_used = rsp_iter_ff;
   assign rsp_limit_reached   = rsp_limit_ff;

`include "interval_maximum_search_unit_assert.svh"

   `IMS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `IMS_ASSERT_NOW(a_iter_bound, rsp_valid, rsp_iterations_used <= max_iter_ff)
   `IMS_ASSERT_NOW(a_limit_flag, rsp_valid,
      rsp_limit_reached == (rsp_iterations_used >= max_iter_ff))
   `IMS_ASSERT_NOW(a_cmp_done_wait, cmp_stat.done, state_ff == S_WAIT)

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for interval_maximum_search_unit.
// Predicts each search answer in SystemVerilog and checks the results in order.
// Depends on ims_pkg and the interval_maximum_search_unit RTL.
module testbench;
   import ims_pkg::*;

   typedef struct {
      logic [WORD_BITS-1:0] best_point;
      logic [ITER_BITS-1:0] iterations_used;
      logic                 limit_reached;
   } search_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WORD_BITS-1:0] req_interval_low = '0;
   logic [WORD_BITS-1:0] req_interval_high = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_BITS-1:0] rsp_best_point;
   logic [ITER_BITS-1:0] rsp_iterations_used;
   logic                 rsp_limit_reached;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [WORD_BITS-1:0] csr_data = '0;

   // Mirror of the configuration registers, reset values.
   logic [WORD_BITS-1:0] cfg_tolerance = 32'd16777;
   logic [ITER_BITS-1:0] cfg_max_iter  = 6'd40;
   logic                 cfg_obj_sel   = 1'b0;

   search_answer_type pending_answers[$];
   int mismatch_count = 0;
   int searches_sent = 0;
   int answers_checked = 0;
   int hold_requests = 0;

   interval_maximum_search_unit u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // True when x*sqrt(10-x) is strictly larger at u than at v.
   function automatic logic root_greater(logic [63:0] u, logic [63:0] v);
      logic [127:0] ten;
      logic [127:0] lhs;
      logic [127:0] rhs;
      ten = 128'(TEN_FIX);
      if (u > ten) return 1'b0;
      if (v > ten) return (u > 0) && (u < ten);
      if (u == v) return 1'b0;
      lhs = ten * (128'(u) + 128'(v));
      rhs = 128'(u) * 128'(u) + 128'(u) * 128'(v) + 128'(v) * 128'(v);
      return (u > v) ? (lhs > rhs) : (lhs < rhs);
   endfunction

   // True when the negative distance function is strictly larger at u than at v.
   function automatic logic dist_greater(logic [63:0] u, logic [63:0] v);
      logic [63:0] q;
      logic [63:0] k;
      if (u == v) return 1'b0;
      q = 64'd89 * (u + v);
      k = 64'd16 << FRAC_BITS;
      return (u > v) ? (q < k) : (q > k);
   endfunction

   function automatic logic objective_greater(logic [63:0] u, logic [63:0] v);
      return cfg_obj_sel ? dist_greater(u, v) : root_greater(u, v);
   endfunction

   function automatic search_answer_type predict_search(logic [WORD_BITS-1:0] lo,
                                                        logic [WORD_BITS-1:0] hi);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] l;
      logic [63:0] r;
      int passes;
      search_answer_type ans;
      a = 64'(lo);
      b = 64'(hi);
      passes = 0;
      forever begin
         c = (a + b) >> 1;
         if (b < a || (b - a) < 64'(cfg_tolerance) || passes >= int'(cfg_max_iter)) break;
         passes++;
         l = (a + c) >> 1;
         r = (c + b) >> 1;
         if (objective_greater(c, l) && objective_greater(c, r)) begin
            a = l;
            b = r;
         end else if (objective_greater(l, r)) begin
            b = c;
         end else begin
            a = c;
         end
      end
      ans.best_point      = c[WORD_BITS-1:0];
      ans.iterations_used = ITER_BITS'(passes);
      ans.limit_reached   = (passes >= int'(cfg_max_iter));
      return ans;
   endfunction

   // Response side: checks each transaction and throttles rsp_ready.
   always @(posedge clock) begin : response_side
      static int stall_left = 0;
      static int holds_seen = 0;
      search_answer_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            answers_checked++;
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response best_point=%h", $time, rsp_best_point);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_best_point !== want.best_point) begin
                  $display("%0t: best_point expected %h actual %h",
                           $time, want.best_point, rsp_best_point);
                  mismatch_count++;
               end
               if (rsp_iterations_used !== want.iterations_used) begin
                  $display("%0t: iterations_used expected %0d actual %0d",
                           $time, want.iterations_used, rsp_iterations_used);
                  mismatch_count++;
               end
               if (rsp_limit_reached !== want.limit_reached) begin
                  $display("%0t: limit_reached expected %b actual %b",
                           $time, want.limit_reached, rsp_limit_reached);
                  mismatch_count++;
               end
            end
         end
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            stall_left = 4000;
         end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                     : $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
   endfunction

   // Offers one search request; entered and left at a rising edge.
   task automatic send_search(logic [WORD_BITS-1:0] lo, logic [WORD_BITS-1:0] hi, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_interval_low  <= lo;
      req_interval_high <= hi;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(predict_search(lo, hi));
      searches_sent++;
   endtask

   // Ends a stream of requests and waits until every answer has come back.
   task automatic drain_searches();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [WORD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_TOLERANCE: cfg_tolerance = value;
         CSR_MAX_ITER:  cfg_max_iter  = value[ITER_BITS-1:0];
         CSR_OBJ_SEL:   cfg_obj_sel   = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [WORD_BITS-1:0] tol, logic [ITER_BITS-1:0] iters,
                            logic sel);
      write_register(CSR_TOLERANCE, tol);
      write_register(CSR_MAX_ITER, WORD_BITS'(iters));
      write_register(CSR_OBJ_SEL, WORD_BITS'(sel));
   endtask

   // Reset configuration: typical, reversed, beyond-ten and tied intervals.
   task automatic test_reset_settings();
      send_search(32'd0, 32'd0, 0);
      send_search(32'd0, TEN_FIX, pick_gap());
      send_search(32'd0, 32'hFFFF_FFFF, pick_gap());
      send_search(32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_gap());
      send_search(32'hFFFF_FFFF, 32'd0, pick_gap());
      send_search(32'd5 << FRAC_BITS, 32'hFFFF_FFFF, pick_gap());
      send_search(32'd11 << FRAC_BITS, 32'd12 << FRAC_BITS, pick_gap());
      send_search(32'h0000_0001, 32'h0000_0002, pick_gap());
      drain_searches();
   endtask

   // Extreme register values on both objectives.
   task automatic test_extreme_settings();
      configure(32'd0, 6'd63, 1'b1);
      send_search(32'd0, 32'd1 << FRAC_BITS, 0);
      send_search(32'd0, 32'hFFFF_FFFF, pick_gap());
      send_search(32'd0, 32'd0, pick_gap());
      send_search(32'd3 << FRAC_BITS, 32'd1 << FRAC_BITS, pick_gap());
      drain_searches();
      configure(32'hFFFF_FFFF, 6'd0, 1'b0);
      send_search(32'd0, 32'hFFFF_FFFF, 0);
      send_search(32'd2 << FRAC_BITS, 32'd9 << FRAC_BITS, pick_gap());
      drain_searches();
      configure(32'd0, 6'd0, 1'b1);
      send_search(32'd0, 32'hFFFF_FFFF, 0);
      drain_searches();
      configure(32'hFFFF_FFFF, 6'd63, 1'b0);
      send_search(32'd0, 32'hFFFF_FFFF, 0);
      send_search(32'h1234_5678, 32'h1234_5678, pick_gap());
      drain_searches();
   endtask

   function automatic logic [WORD_BITS-1:0] random_point(logic near);
      return near ? WORD_BITS'($urandom_range(0, 32'h0FFF_FFFF)) : WORD_BITS'($urandom());
   endfunction

   // Random configurations, mostly ordered intervals with random content.
   task automatic test_random_searches();
      logic [WORD_BITS-1:0] lo;
      logic [WORD_BITS-1:0] hi;
      logic [WORD_BITS-1:0] swap;
      logic near;
      for (int phase = 0; phase < 6; phase++) begin
         configure(($urandom_range(0, 3) == 0) ? WORD_BITS'($urandom())
                                               : WORD_BITS'($urandom_range(0, 200000)),
                   ITER_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         for (int n = 0; n < 20; n++) begin
            near = ($urandom_range(0, 1) == 1);
            lo = random_point(near);
            hi = random_point(near);
            if ($urandom_range(0, 4) != 0 && hi < lo) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            send_search(lo, hi, pick_gap());
         end
         drain_searches();
      end
   endtask

   // The response side holds off while requests keep coming back to back.
   task automatic test_output_backpressure();
      configure(32'd16777, 6'd10, 1'b0);
      hold_requests++;
      for (int n = 0; n < 6; n++) send_search(WORD_BITS'($urandom_range(0, 32'h0400_0000)),
                                              WORD_BITS'($urandom_range(32'h0400_0000,
                                                                        32'h0C00_0000)), 0);
      drain_searches();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_extreme_settings();
      test_random_searches();
      test_output_backpressure();
      repeat (50) @(posedge clock);
      $display("Sent %0d search requests over several register settings",
               searches_sent);
      $display("and checked %0d answers, including a long response stall.", answers_checked);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("interval_maximum_search_unit test passed");
      end else begin
         $display("interval_maximum_search_unit test failed");
      end
      $finish;
   end

   initial begin
      #(20 * 2000000);
      $display("Timeout with %0d answers outstanding.", pending_answers.size());
      $display("interval_maximum_search_unit test failed");
      $finish;
   end

endmodule
